[hw/rtl/sorted_wakeup_timer_queue_top_assert.svh]
// Assertion macros for the sorted wake-up timer queue checker.
`ifndef SORTED_WAKEUP_TIMER_QUEUE_TOP_ASSERT_SVH
`define SORTED_WAKEUP_TIMER_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWTQ_CHK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted wakeup timer queue: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWTQ_CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted wakeup timer queue: next-cycle check failed");

`endif

[hw/rtl/swtq_pkg.sv]
package swtq_pkg;

  localparam logic KIND_SLEEP = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_WOKEN    = 2'd2;

  localparam int unsigned TICK_BITS = 32;
  localparam int unsigned PORT_TID_BITS = 8;

  typedef struct packed {
    logic load;
    logic emit_full;
    logic ins_begin;
    logic ins_step;
    logic ins_stop;
    logic ins_put;
    logic tick_begin;
    logic tick_take;
    logic tick_flush;
  } swtq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic le;
    logic rem_one;
  } swtq_sts_t;

endpackage

[hw/rtl/sorted_wakeup_timer_queue_top.sv]
// Sorted wake-up timer queue. Up to MAX_WAITERS sleeping threads are held in a circular
// buffer in one RAM, ordered by wake tick, with equal ticks kept in arrival order. An item is
// taken when start is high and busy is low. A sleep item on a full queue answers full in the
// next cycle and leaves busy low. An accepted sleep walks back from the tail one slot per
// cycle, shifting later deadlines up, and the accepted result comes in the first cycle with busy
// low again. A tick item reads from the head one slot per cycle and gives one woken result per
// cycle, earliest deadline first, the final one marked by last. A tick that wakes nothing gives
// no result. The single read port of the RAM sets this pace. Results are shown for exactly one
// cycle with result_valid high and cannot be held off, so the receiver must take them as they
// come.
module sorted_wakeup_timer_queue_top #(
  parameter int unsigned MAX_WAITERS    = 16,
  parameter int unsigned THREAD_ID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [7:0]  thread_id,
  input  logic [31:0] wake_tick,
  input  logic [31:0] cur_tick,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [7:0]  woken_thread,
  output logic [31:0] woken_deadline,
  output logic        last
);
  import swtq_pkg::*;

  swtq_cmd_t cmd;
  swtq_sts_t sts;

  swtq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  swtq_dp #(
    .MAX_WAITERS    (MAX_WAITERS),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .kind           (kind),
    .thread_id      (thread_id),
    .wake_tick      (wake_tick),
    .cur_tick       (cur_tick),
    .result_valid   (result_valid),
    .status         (status),
    .woken_thread   (woken_thread),
    .woken_deadline (woken_deadline),
    .last           (last)
  );

endmodule

[hw/rtl/swtq_ram.sv]
module swtq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/swtq_ctrl.sv]
module swtq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               kind,
  input  swtq_pkg::swtq_sts_t sts,
  output swtq_pkg::swtq_cmd_t cmd,
  output logic               busy
);
  import swtq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INS   = 5'b00010,
    S_PUT   = 5'b00100,
    S_TICK  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (kind == KIND_SLEEP) begin
            if (sts.full) begin
              cmd.emit_full = 1'b1;
            end else begin
              cmd.ins_begin = 1'b1;
              state_next    = sts.empty ? S_PUT : S_INS;
            end
          end else if (!sts.empty) begin
            cmd.tick_begin = 1'b1;
            state_next     = S_TICK;
          end
        end
      end
      S_INS: begin
        if (!sts.le) begin
          cmd.ins_step = 1'b1;
          if (sts.rem_one) begin
            state_next = S_PUT;
          end
        end else begin
          cmd.ins_stop = 1'b1;
          state_next   = S_PUT;
        end
      end
      S_PUT: begin
        cmd.ins_put = 1'b1;
        state_next  = S_IDLE;
      end
      S_TICK: begin
        if (sts.le) begin
          cmd.tick_take = 1'b1;
          if (sts.rem_one) begin
            state_next = S_FLUSH;
          end
        end else begin
          cmd.tick_flush = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_FLUSH: begin
        cmd.tick_flush = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/swtq_dp.sv]
module swtq_dp #(
  parameter int unsigned MAX_WAITERS    = 16,
  parameter int unsigned THREAD_ID_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  swtq_pkg::swtq_cmd_t cmd,
  output swtq_pkg::swtq_sts_t sts,
  input  logic                kind,
  input  logic [7:0]          thread_id,
  input  logic [31:0]         wake_tick,
  input  logic [31:0]         cur_tick,
  output logic                result_valid,
  output logic [1:0]          status,
  output logic [7:0]          woken_thread,
  output logic [31:0]         woken_deadline,
  output logic                last
);
  import swtq_pkg::*;

  localparam int unsigned TB = THREAD_ID_BITS;
  localparam int unsigned AW = $clog2(MAX_WAITERS);
  localparam int unsigned CW = $clog2(MAX_WAITERS + 1);
  localparam int unsigned DW = TICK_BITS + TB;
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WAITERS - 1);
  localparam logic [CW:0]   DEPTH_W   = (CW + 1)'(MAX_WAITERS);

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic          pend_valid;

  logic          kind_r;
  logic [TB-1:0] tid_r;
  logic [31:0]   wake_r;
  logic [31:0]   now_r;
  logic [AW-1:0] ptr;
  logic [AW-1:0] wr_ptr;
  logic [CW-1:0] rem;
  logic [TB-1:0] pend_tid;
  logic [31:0]   pend_dl;

  logic [AW-1:0] ptr_inc;
  logic [AW-1:0] ptr_dec;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] tail_dec;
  logic [31:0]   key;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;
  logic [31:0]   rd_dl;
  logic [TB-1:0] rd_tid;

  logic [TB+7:0] tid_in_ext;
  logic [TB+7:0] tid_out_ext;

  logic          emit;
  logic [1:0]    emit_status;
  logic [7:0]    emit_tid;
  logic [31:0]   emit_dl;
  logic          emit_last;

  swtq_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_WAITERS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_dl  = ram_rdata[DW-1:TB];
  assign rd_tid = ram_rdata[TB-1:0];

  assign ptr_inc = (ptr == LAST_SLOT) ? '0 : ptr + AW'(1);
  assign ptr_dec = (ptr == '0) ? LAST_SLOT : ptr - AW'(1);

  always_comb begin
    tail_sum = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, count};
    if (tail_sum >= DEPTH_W) begin
      tail_sum = tail_sum - DEPTH_W;
    end
    tail     = tail_sum[AW-1:0];
    tail_dec = (tail == '0) ? LAST_SLOT : tail - AW'(1);
  end

  assign key = (kind_r == KIND_TICK) ? now_r : wake_r;

  assign sts.full    = (count == CW'(MAX_WAITERS));
  assign sts.empty   = (count == '0);
  assign sts.le      = (rd_dl <= key);
  assign sts.rem_one = (rem == CW'(1));

  assign tid_in_ext  = {{TB{1'b0}}, thread_id};
  assign tid_out_ext = {8'b0, pend_tid};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_ptr;
    ram_wdata = {wake_r, tid_r};
    ram_raddr = ptr;
    if (cmd.ins_begin) begin
      ram_raddr = tail_dec;
    end
    if (cmd.ins_step) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_inc;
      ram_wdata = ram_rdata;
      ram_raddr = ptr_dec;
    end
    if (cmd.ins_put) begin
      ram_we = 1'b1;
    end
    if (cmd.tick_begin) begin
      ram_raddr = head;
    end
    if (cmd.tick_take) begin
      ram_raddr = ptr_inc;
    end
  end

  always_comb begin
    emit        = 1'b0;
    emit_status = ST_WOKEN;
    emit_tid    = tid_out_ext[7:0];
    emit_dl     = pend_dl;
    emit_last   = 1'b0;
    if (cmd.emit_full) begin
      emit        = 1'b1;
      emit_status = ST_FULL;
      emit_tid    = '0;
      emit_dl     = '0;
      emit_last   = 1'b1;
    end
    if (cmd.ins_put) begin
      emit        = 1'b1;
      emit_status = ST_ACCEPTED;
      emit_tid    = '0;
      emit_dl     = '0;
      emit_last   = 1'b1;
    end
    if (cmd.tick_take && pend_valid) begin
      emit = 1'b1;
    end
    if (cmd.tick_flush && pend_valid) begin
      emit      = 1'b1;
      emit_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      count        <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
      if (cmd.ins_put) begin
        count <= count + CW'(1);
      end
      if (cmd.tick_begin || cmd.tick_flush) begin
        pend_valid <= 1'b0;
      end
      if (cmd.tick_take) begin
        pend_valid <= 1'b1;
        head       <= ptr_inc;
        count      <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status         <= emit_status;
      woken_thread   <= emit_tid;
      woken_deadline <= emit_dl;
      last           <= emit_last;
    end
    if (cmd.load) begin
      kind_r <= kind;
      tid_r  <= tid_in_ext[TB-1:0];
      wake_r <= wake_tick;
      now_r  <= cur_tick;
    end
    if (cmd.ins_begin) begin
      ptr    <= tail_dec;
      rem    <= count;
      wr_ptr <= tail;
    end
    if (cmd.ins_step) begin
      ptr    <= ptr_dec;
      rem    <= rem - CW'(1);
      wr_ptr <= ptr;
    end
    if (cmd.ins_stop) begin
      wr_ptr <= ptr_inc;
    end
    if (cmd.tick_begin) begin
      ptr <= head;
      rem <= count;
    end
    if (cmd.tick_take) begin
      pend_tid <= rd_tid;
      pend_dl  <= rd_dl;
      ptr      <= ptr_inc;
      rem      <= rem - CW'(1);
    end
  end

endmodule

[hw/rtl/swtq_checker.sv]
`include "sorted_wakeup_timer_queue_top_assert.svh"

module swtq_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        result_valid,
  input logic [1:0]  status,
  input logic [7:0]  woken_thread,
  input logic [31:0] woken_deadline,
  input logic        last
);
  import swtq_pkg::*;

  logic single_res;
  logic woken_more;

  assign single_res = result_valid && status != ST_WOKEN;
  assign woken_more = result_valid && status == ST_WOKEN && !last;

  `SWTQ_CHK_SAME(a_single_is_last, single_res, last)
  `SWTQ_CHK_SAME(a_single_zero, single_res, woken_thread == 8'd0 && woken_deadline == 32'd0)
  `SWTQ_CHK_NEXT(a_burst_unbroken, woken_more, result_valid && status == ST_WOKEN)
  `SWTQ_CHK_SAME(a_burst_busy, woken_more, busy)
  `SWTQ_CHK_NEXT(a_burst_sorted, woken_more, woken_deadline >= $past(woken_deadline))

endmodule

bind sorted_wakeup_timer_queue_top swtq_checker u_swtq_checker (.*);

[verif/testbench.sv]
module testbench;
  import swtq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 336;
  localparam int CALM_ITEMS = 50;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  thread;
    logic [31:0] deadline;
    logic        last;
  } wake_result_t;

  typedef struct packed {
    logic [7:0]  tid;
    logic [31:0] wake;
  } sleeper_t;

  typedef struct packed {
    logic         kind;
    logic [7:0]   tid;
    logic [31:0]  wake;
    logic [31:0]  now;
    logic         typed;
    wake_result_t want;
  } stim_row_t;

  localparam wake_result_t NO_RESULT = '0;
  localparam wake_result_t ACCEPT_ONLY = '{ST_ACCEPTED, 8'd0, 32'd0, 1'b1};
  localparam wake_result_t FULL_ONLY = '{ST_FULL, 8'd0, 32'd0, 1'b1};

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        kind;
  logic [7:0]  thread_id;
  logic [31:0] wake_tick;
  logic [31:0] cur_tick;
  logic        result_valid;
  logic [1:0]  status;
  logic [7:0]  woken_thread;
  logic [31:0] woken_deadline;
  logic        last;

  sleeper_t     sleepers[$];
  wake_result_t fresh_results[$];
  wake_result_t awaited_results[$];
  int           error_count = 0;
  int           cycle_count = 0;
  logic [31:0]  sim_now = '0;

  // Equal deadlines stay in arrival order; a sleep that is earlier than the head goes in front.
  stim_row_t directed_rows [0:24] = '{
    '{KIND_TICK,  8'hAA, 32'h5555_5555, 32'd0,         1'b0, NO_RESULT},
    '{KIND_SLEEP, 8'h00, 32'd0,         32'hFFFF_FFFF, 1'b1, ACCEPT_ONLY},
    '{KIND_TICK,  8'h00, 32'd0,         32'd0,         1'b1,
      '{ST_WOKEN, 8'h00, 32'd0, 1'b1}},
    '{KIND_SLEEP, 8'hFF, 32'hFFFF_FFFF, 32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_TICK,  8'h00, 32'd0,         32'hFFFF_FFFE, 1'b0, NO_RESULT},
    '{KIND_TICK,  8'h55, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b1,
      '{ST_WOKEN, 8'hFF, 32'hFFFF_FFFF, 1'b1}},
    '{KIND_SLEEP, 8'd1,  32'd100,       32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd2,  32'd50,        32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd3,  32'd100,       32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd4,  32'd7,         32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd5,  32'hFFFF_FFFF, 32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd6,  32'd0,         32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd7,  32'd100,       32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd8,  32'd200,       32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd9,  32'h8000_0000, 32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd10, 32'd50,        32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd11, 32'd1,         32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd12, 32'h7FFF_FFFF, 32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd13, 32'd100,       32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd14, 32'd0,         32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd15, 32'hFFFF_FFFF, 32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'd16, 32'd300,       32'd0,         1'b1, ACCEPT_ONLY},
    '{KIND_SLEEP, 8'h77, 32'd5,         32'd0,         1'b1, FULL_ONLY},
    '{KIND_TICK,  8'h00, 32'd0,         32'd100,       1'b0, NO_RESULT},
    '{KIND_TICK,  8'h00, 32'd0,         32'hFFFF_FFFF, 1'b0, NO_RESULT}
  };

  sorted_wakeup_timer_queue_top #(
    .MAX_WAITERS(QUEUE_DEPTH),
    .THREAD_ID_BITS(8)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .thread_id(thread_id),
    .wake_tick(wake_tick),
    .cur_tick(cur_tick),
    .result_valid(result_valid),
    .status(status),
    .woken_thread(woken_thread),
    .woken_deadline(woken_deadline),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void predict_wakeups(input stim_row_t item);
    int pos;
    sleeper_t entry;
    wake_result_t woken;
    fresh_results = {};
    if (item.kind == KIND_SLEEP) begin
      if (sleepers.size() >= QUEUE_DEPTH) begin
        fresh_results.push_back(FULL_ONLY);
      end else begin
        pos = 0;
        while (pos < sleepers.size() && sleepers[pos].wake <= item.wake) pos++;
        entry.tid = item.tid;
        entry.wake = item.wake;
        sleepers.insert(pos, entry);
        fresh_results.push_back(ACCEPT_ONLY);
      end
    end else begin
      while (sleepers.size() > 0 && sleepers[0].wake <= item.now) begin
        entry = sleepers.pop_front();
        woken.status = ST_WOKEN;
        woken.thread = entry.tid;
        woken.deadline = entry.wake;
        woken.last = !(sleepers.size() > 0 && sleepers[0].wake <= item.now);
        fresh_results.push_back(woken);
      end
    end
  endfunction

  function automatic stim_row_t random_row(input int sleep_pct);
    stim_row_t item;
    item = '0;
    item.tid = 8'($urandom);
    item.wake = $urandom;
    item.now = $urandom;
    if ($urandom_range(0, 49) == 0) sim_now = $urandom;
    if ($urandom_range(0, 99) < sleep_pct) begin
      item.kind = KIND_SLEEP;
      if ($urandom_range(0, 9) != 0) item.wake = sim_now + $urandom_range(0, 40);
    end else begin
      item.kind = KIND_TICK;
      if ($urandom_range(0, 19) != 0) begin
        sim_now = sim_now + $urandom_range(0, 25);
        item.now = sim_now;
      end
    end
    return item;
  endfunction

  task automatic send_item(input stim_row_t item, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= item.kind;
    thread_id <= item.tid;
    wake_tick <= item.wake;
    cur_tick <= item.now;
    do @(posedge clk); while (busy !== 1'b0);
    predict_wakeups(item);
    if (item.typed) begin
      awaited_results.push_back(item.want);
    end else begin
      foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  always @(posedge clk) begin
    wake_result_t want;
    if (!rst && result_valid === 1'b1) begin
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("unexpected result %0d/%0d/%h/%b",
                               status, woken_thread, woken_deadline, last));
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.status || woken_thread !== want.thread ||
            woken_deadline !== want.deadline || last !== want.last) begin
          note_failure($sformatf("expected %0d/%0d/%h/%b, got %0d/%0d/%h/%b",
                                 want.status, want.thread, want.deadline, want.last,
                                 status, woken_thread, woken_deadline, last));
        end
      end
    end
  end

  initial begin
    int gap;
    int sleep_pct;
    rst <= 1'b1;
    start <= 1'b0;
    kind <= KIND_SLEEP;
    thread_id <= '0;
    wake_tick <= '0;
    cur_tick <= '0;
    sleep_pct = 55;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
      send_item(directed_rows[i], gap);
    end
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: sleep_pct = 30;
          1: sleep_pct = 55;
          default: sleep_pct = 80;
        endcase
      end
      if (n == RANDOM_ITEMS / 2) drain_results();
      gap = (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0) ?
            $urandom_range(1, 5) : 0;
      send_item(random_row(sleep_pct), gap);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", awaited_results.size()));
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
